// File: sv/rgb_to_hsi_pixel_unit_macros.svh
// Assertion macros shared by the checker of the RGB to HSI pixel unit.
`ifndef RGB_TO_HSI_PIXEL_UNIT_MACROS_SVH
`define RGB_TO_HSI_PIXEL_UNIT_MACROS_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define RGBHSI_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The expression must never be true, outside reset.
`define RGBHSI_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");

`endif

// File: sv/rgbhsi_pkg.sv
// Types and constants of the RGB to HSI pixel pipeline.
`timescale 1ns / 1ps
package rgbhsi_pkg;
   localparam int XY_W     = 32;
   localparam int Z_W      = 26;
   localparam int REM_W    = 18;
   localparam int DEN_W    = 10;
   localparam int QUOT_W   = 8;
   localparam int STEPS    = 20;
   localparam int FRAC     = 16;
   localparam int LATENCY  = STEPS + 3;
   localparam logic [16:0] SQRT3_Q16 = 17'd113512;
   localparam logic signed [Z_W-1:0] DEG90  = Z_W'(90 << FRAC);
   localparam logic signed [Z_W-1:0] DEG180 = Z_W'(180 << FRAC);
   localparam logic signed [Z_W-1:0] DEG360 = Z_W'(360 << FRAC);

   typedef logic signed [Z_W-1:0] atan_table_type [STEPS];
   localparam atan_table_type ATAN_DEG = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
      26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334,
      26'sd3667, 26'sd1833, 26'sd917, 26'sd458, 26'sd229,
      26'sd115, 26'sd57, 26'sd29, 26'sd14, 26'sd7
   };

   typedef struct packed {
      logic                    valid;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
      logic [REM_W-1:0]        rem;
      logic [DEN_W-1:0]        den;
      logic [QUOT_W-1:0]       quot;
      logic                    mirror;
      logic                    gray;
      logic [7:0]              inten;
   } stage_type;
endpackage

// File: sv/rgbhsi_prep.sv
// Two front stages: channel sums, minimum, chroma vector and prerotation.
`timescale 1ns / 1ps
module rgbhsi_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_in,
   input  logic [7:0]            blue_in,
   input  logic [7:0]            green_in,
   input  logic [7:0]            red_in,
   output rgbhsi_pkg::stage_type stage_out
);
   logic              a_valid_ff, a_valid_in;
   logic signed [10:0] a_dx_ff, a_dx_in;
   logic [7:0]         a_dgb_ff, a_dgb_in;
   logic               a_mirror_ff, a_mirror_in;
   logic               a_gray_ff, a_gray_in;
   logic [9:0]         a_sum_ff, a_sum_in;
   logic [9:0]         a_spread_ff, a_spread_in;
   logic [7:0]         mn;
   logic [9:0]         mn3;
   rgbhsi_pkg::stage_type b_ff, b_in;
   logic [24:0]        y_mag;
   logic signed [rgbhsi_pkg::XY_W-1:0] x_full, y_full;
   logic [19:0]        inten_prod;

   always_comb begin
      mn = red_in;
      if (green_in < mn) mn = green_in;
      if (blue_in < mn) mn = blue_in;
      mn3 = {2'b00, mn} + {1'b0, mn, 1'b0};
      a_valid_in  = valid_in;
      a_sum_in    = 10'(red_in) + 10'(green_in) + 10'(blue_in);
      a_spread_in = a_sum_in - mn3;
      a_gray_in   = (mn3 == a_sum_in);
      a_dx_in     = $signed({2'b00, red_in, 1'b0}) - $signed({3'b000, green_in})
                    - $signed({3'b000, blue_in});
      a_mirror_in = blue_in > green_in;
      a_dgb_in    = a_mirror_in ? blue_in - green_in : green_in - blue_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      a_dx_ff     <= a_dx_in;
      a_dgb_ff    <= a_dgb_in;
      a_mirror_ff <= a_mirror_in;
      a_gray_ff   <= a_gray_in;
      a_sum_ff    <= a_sum_in;
      a_spread_ff <= a_spread_in;
   end

   always_comb begin
      y_mag      = 25'(a_dgb_ff) * 25'(rgbhsi_pkg::SQRT3_Q16);
      x_full     = rgbhsi_pkg::XY_W'(a_dx_ff) <<< rgbhsi_pkg::FRAC;
      y_full     = $signed({7'b0, y_mag});
      inten_prod = 20'(a_sum_ff) * 20'd683;
      b_in        = '0;
      b_in.valid  = a_valid_ff;
      b_in.mirror = a_mirror_ff;
      b_in.gray   = a_gray_ff;
      b_in.den    = a_sum_ff;
      b_in.quot   = '0;
      b_in.rem    = ({8'b0, a_spread_ff} << 8) - {8'b0, a_spread_ff};
      b_in.inten  = inten_prod[18:11];
      // A vector in the left half plane is turned by 90 degrees first.
      if (a_dx_ff < 0) begin
         b_in.x = y_full;
         b_in.y = -x_full;
         b_in.z = rgbhsi_pkg::DEG90;
      end else begin
         b_in.x = x_full;
         b_in.y = y_full;
         b_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= '0;
      end else begin
         b_ff <= b_in;
      end
   end

   assign stage_out = b_ff;
endmodule

// File: sv/rgbhsi_cordic_stage.sv
// One CORDIC vectoring step, plus one saturation quotient bit in early stages.
`timescale 1ns / 1ps
module rgbhsi_cordic_stage #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rgbhsi_pkg::stage_type stage_in,
   output rgbhsi_pkg::stage_type stage_out
);
   rgbhsi_pkg::stage_type st_ff, st_in;
   logic signed [rgbhsi_pkg::XY_W-1:0] xs, ys;
   logic [rgbhsi_pkg::REM_W-1:0]  div_rem;
   logic [rgbhsi_pkg::QUOT_W-1:0] div_quot;

   generate
      if (STEP < rgbhsi_pkg::QUOT_W) begin : g_div
         localparam int BIT = rgbhsi_pkg::QUOT_W - 1 - STEP;
         logic [rgbhsi_pkg::REM_W-1:0] trial;
         always_comb begin
            trial    = rgbhsi_pkg::REM_W'(stage_in.den) << BIT;
            div_rem  = stage_in.rem;
            div_quot = stage_in.quot;
            if (stage_in.rem >= trial) begin
               div_rem       = stage_in.rem - trial;
               div_quot[BIT] = 1'b1;
            end
         end
      end else begin : g_nodiv
         assign div_rem  = stage_in.rem;
         assign div_quot = stage_in.quot;
      end
   endgenerate

   always_comb begin
      xs = stage_in.x >>> STEP;
      ys = stage_in.y >>> STEP;
      st_in      = stage_in;
      st_in.rem  = div_rem;
      st_in.quot = div_quot;
      if (stage_in.y >= 0) begin
         st_in.x = stage_in.x + ys;
         st_in.y = stage_in.y - xs;
         st_in.z = stage_in.z + rgbhsi_pkg::ATAN_DEG[STEP];
      end else begin
         st_in.x = stage_in.x - ys;
         st_in.y = stage_in.y + xs;
         st_in.z = stage_in.z - rgbhsi_pkg::ATAN_DEG[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   assign stage_out = st_ff;
endmodule

// File: sv/rgbhsi_finish.sv
// Output stage: angle clamp, mirroring, halving and the gray override.
`timescale 1ns / 1ps
module rgbhsi_finish (
   input  logic                  clock,
   input  logic                  reset,
   input  rgbhsi_pkg::stage_type stage_in,
   output logic                  valid_out,
   output logic [7:0]            hue_half,
   output logic [7:0]            saturation_out,
   output logic [7:0]            intensity_out
);
   logic              valid_ff, valid_in;
   logic [7:0]        hue_ff, hue_in, sat_ff, sat_in, inten_ff, inten_in;
   logic signed [rgbhsi_pkg::Z_W-1:0] ang, hue;
   logic [rgbhsi_pkg::Z_W-1:0] hue_shift;

   always_comb begin
      ang = stage_in.z;
      if (ang < 0) ang = '0;
      if (ang > rgbhsi_pkg::DEG180) ang = rgbhsi_pkg::DEG180;
      hue = stage_in.mirror ? rgbhsi_pkg::DEG360 - ang : ang;
      hue_shift = rgbhsi_pkg::Z_W'(hue >>> (rgbhsi_pkg::FRAC + 1));
      hue_in = (hue_shift > 179) ? 8'd179 : hue_shift[7:0];
      sat_in = stage_in.quot;
      // Gray and black pixels have no hue and no saturation.
      if (stage_in.gray) begin
         hue_in = '0;
         sat_in = '0;
      end
      inten_in = stage_in.inten;
      valid_in = stage_in.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      hue_ff   <= hue_in;
      sat_ff   <= sat_in;
      inten_ff <= inten_in;
   end

   assign valid_out      = valid_ff;
   assign hue_half       = hue_ff;
   assign saturation_out = sat_ff;
   assign intensity_out  = inten_ff;
endmodule

// File: sv/rgb_to_hsi_pixel_unit.sv
// Throughput: one pixel per cycle; busy stays low, as the 23-stage pipeline
// (two front stages, twenty CORDIC steps, one output stage) never stalls.
// The saturation quotient is formed one bit per stage in the first eight steps.
// Synchronous reset clears all stage valid bits; pixels in flight are dropped.
`timescale 1ns / 1ps
module rgb_to_hsi_pixel_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_blue_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_red_in,
   output logic       rsp_valid,
   output logic [7:0] rsp_hue_half,
   output logic [7:0] rsp_saturation_out,
   output logic [7:0] rsp_intensity_out
);
   rgbhsi_pkg::stage_type pipe [rgbhsi_pkg::STEPS+1];

   assign busy = 1'b0;

   rgbhsi_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (start),
      .blue_in   (req_blue_in),
      .green_in  (req_green_in),
      .red_in    (req_red_in),
      .stage_out (pipe[0])
   );

   generate
      for (genvar i = 0; i < rgbhsi_pkg::STEPS; i++) begin : g_step
         rgbhsi_cordic_stage #(.STEP(i)) u_stage (
            .clock     (clock),
            .reset     (reset),
            .stage_in  (pipe[i]),
            .stage_out (pipe[i+1])
         );
      end
   endgenerate

   rgbhsi_finish u_finish (
      .clock          (clock),
      .reset          (reset),
      .stage_in       (pipe[rgbhsi_pkg::STEPS]),
      .valid_out      (rsp_valid),
      .hue_half       (rsp_hue_half),
      .saturation_out (rsp_saturation_out),
      .intensity_out  (rsp_intensity_out)
   );
endmodule

// File: sv/rgbhsi_checker.sv
// Port-level checker for the RGB to HSI pixel unit and its bind.
`timescale 1ns / 1ps
`include "rgb_to_hsi_pixel_unit_macros.svh"
module rgbhsi_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [7:0] req_blue_in,
   input logic [7:0] req_green_in,
   input logic [7:0] req_red_in,
   input logic       rsp_valid,
   input logic [7:0] rsp_hue_half,
   input logic [7:0] rsp_saturation_out
);
   // Every accepted transaction yields a result after the fixed latency.
   `RGBHSI_ASSERT_IMPL(a_latency, clock, reset, start && !busy, ##23 rsp_valid)
   // A gray pixel comes out with zero hue and zero saturation.
   `RGBHSI_ASSERT_IMPL(a_gray, clock, reset, start && !busy && req_red_in == req_green_in && req_green_in == req_blue_in, ##23 (rsp_hue_half == 8'd0 && rsp_saturation_out == 8'd0))
   `RGBHSI_ASSERT_NEVER(a_hue_range, clock, reset, rsp_valid && rsp_hue_half > 8'd179)
   `RGBHSI_ASSERT_NEVER(a_never_busy, clock, reset, busy)
endmodule

bind rgb_to_hsi_pixel_unit rgbhsi_checker u_rgbhsi_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_blue_in        (req_blue_in),
   .req_green_in       (req_green_in),
   .req_red_in         (req_red_in),
   .rsp_valid          (rsp_valid),
   .rsp_hue_half       (rsp_hue_half),
   .rsp_saturation_out (rsp_saturation_out)
);

// File: bench/rgb_to_hsi_pixel_unit_tb.sv
// Self-checking testbench of the RGB to HSI pixel unit with a fixed-point HSI predictor.
`timescale 1ns / 1ps
module rgb_to_hsi_pixel_unit_tb;

   typedef struct packed {
      logic [7:0] hue_half;
      logic [7:0] saturation;
      logic [7:0] intensity;
   } hsi_pixel_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [7:0] req_blue_in;
   logic [7:0] req_green_in;
   logic [7:0] req_red_in;
   logic       rsp_valid;
   logic [7:0] rsp_hue_half;
   logic [7:0] rsp_saturation_out;
   logic [7:0] rsp_intensity_out;

   hsi_pixel_type pending_pixels[$];
   int unsigned   error_count;
   int unsigned   cycle_count;

   // Arctangent of 2^-i in Q16 degrees.
   localparam longint ATAN_Q16 [20] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
   };
   localparam int    CYCLE_LIMIT = 200000;

   rgb_to_hsi_pixel_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_blue_in(req_blue_in), .req_green_in(req_green_in), .req_red_in(req_red_in),
      .rsp_valid(rsp_valid), .rsp_hue_half(rsp_hue_half),
      .rsp_saturation_out(rsp_saturation_out), .rsp_intensity_out(rsp_intensity_out)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Q16 angle of the chroma vector, 0..180 degrees, by 20 vectoring steps.
   function automatic longint chroma_angle(longint x, longint y);
      longint z, xs, ys, t;
      z = 0;
      if (y < 0) y = -y;
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         z = 90 <<< 16;
      end
      for (int i = 0; i < 20; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_Q16[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_Q16[i];
         end
      end
      if (z < 0) z = 0;
      if (z > (180 <<< 16)) z = 180 <<< 16;
      return z;
   endfunction

   function automatic hsi_pixel_type convert_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      hsi_pixel_type p;
      longint sum, mn, hue, hh;
      sum = longint'(r) + g + b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      p.intensity = 8'(sum / 3);
      if (sum == 0 || 3 * mn == sum) begin
         p.saturation = 8'd0;
         p.hue_half = 8'd0;
      end else begin
         p.saturation = 8'((255 * (sum - 3 * mn)) / sum);
         hue = chroma_angle((2 * longint'(r) - g - b) <<< 16,
                            (longint'(g) - longint'(b)) * 113512);
         if (b > g) hue = (360 <<< 16) - hue;
         hh = hue >>> 17;
         if (hh > 179) hh = 179;
         p.hue_half = 8'(hh);
      end
      return p;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Sends one pixel after a random gap; the transaction is taken when busy is low.
   task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int gap;
      gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_blue_in <= b;
      req_green_in <= g;
      req_red_in <= r;
      do @(posedge clock); while (busy);
      pending_pixels.push_back(convert_pixel(b, g, r));
   endtask

   always @(posedge clock) begin
      hsi_pixel_type want;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_hue_half != want.hue_half)
               report_mismatch("hue_half", rsp_hue_half, want.hue_half);
            if (rsp_saturation_out != want.saturation)
               report_mismatch("saturation_out", rsp_saturation_out, want.saturation);
            if (rsp_intensity_out != want.intensity)
               report_mismatch("intensity_out", rsp_intensity_out, want.intensity);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic test_extremes();
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd77, 8'd77, 8'd77);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd1, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd254, 8'd255);
   endtask

   // Blue equal to green puts the hue at 0 or at 180 degrees.
   task automatic test_blue_equals_green();
      send_pixel(8'd40, 8'd40, 8'd200);
      send_pixel(8'd200, 8'd200, 8'd40);
      send_pixel(8'd0, 8'd0, 8'd1);
      send_pixel(8'd255, 8'd255, 8'd254);
      send_pixel(8'd128, 8'd128, 8'd129);
      send_pixel(8'd128, 8'd128, 8'd127);
   endtask

   task automatic test_random_pixels(int count);
      logic [7:0] b, g, r;
      for (int n = 0; n < count; n++) begin
         b = 8'($urandom);
         g = 8'($urandom);
         r = 8'($urandom);
         case ($urandom_range(0, 9))
            0: g = b;
            1: begin g = b; r = b; end
            2: r = 8'(b + $urandom_range(0, 2));
            default: ;
         endcase
         send_pixel(b, g, r);
      end
   endtask

   initial begin
      int drain;
      error_count = 0;
      cycle_count = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_blue_in <= 8'd0;
      req_green_in <= 8'd0;
      req_red_in <= 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_blue_equals_green();
      test_random_pixels(1800);
      start <= 1'b0;
      drain = 0;
      while (pending_pixels.size() != 0 && drain < 1000) begin
         @(posedge clock);
         drain++;
      end
      repeat (rgbhsi_pkg::LATENCY + 5) @(posedge clock);
      if (error_count == 0 && pending_pixels.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// File: filelist.f
+incdir+sv
sv/rgbhsi_pkg.sv
sv/rgbhsi_prep.sv
sv/rgbhsi_cordic_stage.sv
sv/rgbhsi_finish.sv
sv/rgb_to_hsi_pixel_unit.sv
sv/rgbhsi_checker.sv
bench/rgb_to_hsi_pixel_unit_tb.sv
